// ----- rtl/grsu_pkg.sv -----
// Shared types and constants for the gamepad report state update unit.
// Operation codes, field widths, motion scaling constants, lane and result types.
// No dependencies.
package grsu_pkg;

	localparam int BUTTON_COUNT = 16;
	localparam int AXIS_COUNT   = 6;

	localparam int OP_W     = 3;
	localparam int INDEX_W  = 5;
	localparam int WORD_W   = 16;
	localparam int MOTION_W = 32;
	localparam int LANE_COUNT = 3;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR      = 3'd0,
		OP_SET_BUTTON = 3'd1,
		OP_SET_AXIS   = 3'd2,
		OP_SET_ACCEL  = 3'd3,
		OP_SET_GYRO   = 3'd4
	} op_t;

	// Full range in Q15.16, rounded to nearest.
	localparam int ACCEL_RANGE = 1285377;
	localparam int GYRO_RANGE  = 2287638;
	localparam int ACCEL_DIV   = 2 * ACCEL_RANGE;
	localparam int GYRO_DIV    = 2 * GYRO_RANGE;

	// Numerator 65535*r - R fits in 49 signed bits.
	localparam int NUM_W = MOTION_W + 17;
	// Unsaturated magnitudes stay below 32768 * GYRO_DIV.
	localparam int MAG_W = 38;
	localparam int DIV_W = 23;
	localparam int QUO_W = WORD_W - 1;

	// Quotient estimate: drop the low magnitude bits, multiply by floor(2^40 / divisor).
	// The estimate is never high and at most one low; one compare fixes it.
	localparam int EST_DROP    = 6;
	localparam int EST_W       = MAG_W - EST_DROP;
	localparam int RECIP_SHIFT = 40;
	localparam int RECIP_W     = 20;
	localparam int PROD_W      = EST_W + RECIP_W;
	localparam int BND_W       = WORD_W + 1 + DIV_W;
	localparam longint ACCEL_RECIP = (longint'(1) << RECIP_SHIFT) / longint'(ACCEL_DIV);
	localparam longint GYRO_RECIP  = (longint'(1) << RECIP_SHIFT) / longint'(GYRO_DIV);

	localparam longint ACCEL_SAT_L = longint'(32768) * longint'(ACCEL_DIV);
	localparam longint GYRO_SAT_L  = longint'(32768) * longint'(GYRO_DIV);
	localparam logic signed [NUM_W-1:0] ACCEL_SAT = NUM_W'(ACCEL_SAT_L);
	localparam logic signed [NUM_W-1:0] GYRO_SAT  = NUM_W'(GYRO_SAT_L);

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic  done;
		word_t word;
	} lane_out_t;

	typedef struct packed {
		logic  changed;
		logic  bad_index;
		word_t button_mask;
	} result_t;

endpackage

// ----- rtl/grsu_cmd_if.sv -----
// Input channel of the gamepad report state update unit: one operation per item.
// Depends on grsu_pkg for field widths.
interface grsu_cmd_if;
	logic                                   valid;
	logic                                   ready;
	logic [grsu_pkg::OP_W-1:0]              operation;
	logic [grsu_pkg::INDEX_W-1:0]           index;
	logic                                   pressed;
	logic signed [grsu_pkg::WORD_W-1:0]     axis_value;
	logic signed [grsu_pkg::MOTION_W-1:0]   motion_x;
	logic signed [grsu_pkg::MOTION_W-1:0]   motion_y;
	logic signed [grsu_pkg::MOTION_W-1:0]   motion_z;

	modport source (
		output valid, operation, index, pressed, axis_value, motion_x, motion_y, motion_z,
		input  ready
	);
	modport sink (
		input  valid, operation, index, pressed, axis_value, motion_x, motion_y, motion_z,
		output ready
	);
endinterface

// ----- rtl/grsu_rpt_if.sv -----
// Result channel of the gamepad report state update unit: one report item per operation.
// Depends on grsu_pkg for field widths.
interface grsu_rpt_if;
	logic                        valid;
	logic                        ready;
	logic                        changed;
	logic                        bad_index;
	logic [grsu_pkg::WORD_W-1:0] button_mask;

	modport source (
		output valid, changed, bad_index, button_mask,
		input  ready
	);
	modport sink (
		input  valid, changed, bad_index, button_mask,
		output ready
	);
endinterface

// ----- rtl/grsu_lane.sv -----
// One motion scaling lane: maps a Q15.16 reading onto a saturated 16-bit word.
// Divides by twice the constant full range with a reciprocal multiply and one correction step.
// Depends on grsu_pkg.
module grsu_lane (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 gyro_sel,
	input  logic signed [grsu_pkg::MOTION_W-1:0] raw,
	output grsu_pkg::lane_out_t                  lane_out
);

	typedef enum logic [2:0] {
		L_IDLE,
		L_PREP,
		L_EST,
		L_FIX,
		L_DONE
	} lane_state_t;

	lane_state_t                           state_q;
	logic                                  gyro_q;
	logic                                  done_q;
	logic signed [grsu_pkg::NUM_W-1:0]     num_q;
	logic [grsu_pkg::MAG_W-1:0]            mag_q;
	logic [grsu_pkg::WORD_W-1:0]           est_q;
	logic [grsu_pkg::QUO_W-1:0]            quo_q;
	logic                                  neg_q;
	logic                                  pos_sat_q;
	logic                                  neg_sat_q;

	logic signed [grsu_pkg::NUM_W-1:0]     raw_x;
	logic signed [grsu_pkg::NUM_W-1:0]     range_x;
	logic signed [grsu_pkg::NUM_W-1:0]     num_d;
	logic signed [grsu_pkg::NUM_W-1:0]     sat_lim;
	logic signed [grsu_pkg::NUM_W-1:0]     num_abs;
	logic [grsu_pkg::DIV_W-1:0]            div_val;
	logic [grsu_pkg::RECIP_W-1:0]          recip;
	logic [grsu_pkg::PROD_W-1:0]           est_prod;
	logic [grsu_pkg::WORD_W:0]             est_inc;
	logic [grsu_pkg::BND_W-1:0]            bound;
	logic                                  take;
	logic [grsu_pkg::WORD_W-1:0]           quo_x;

	// 65535*r - R as a shift and two subtracts
	assign raw_x   = grsu_pkg::NUM_W'(raw);
	assign range_x = gyro_sel ? grsu_pkg::NUM_W'(grsu_pkg::GYRO_RANGE)
	                          : grsu_pkg::NUM_W'(grsu_pkg::ACCEL_RANGE);
	assign num_d   = (raw_x <<< 16) - raw_x - range_x;

	assign sat_lim = gyro_q ? grsu_pkg::GYRO_SAT : grsu_pkg::ACCEL_SAT;
	assign num_abs = num_q[grsu_pkg::NUM_W-1] ? -num_q : num_q;
	assign div_val = gyro_q ? grsu_pkg::DIV_W'(grsu_pkg::GYRO_DIV)
	                        : grsu_pkg::DIV_W'(grsu_pkg::ACCEL_DIV);
	assign recip   = gyro_q ? grsu_pkg::RECIP_W'(grsu_pkg::GYRO_RECIP)
	                        : grsu_pkg::RECIP_W'(grsu_pkg::ACCEL_RECIP);

	assign est_prod = grsu_pkg::PROD_W'(mag_q[grsu_pkg::MAG_W-1:grsu_pkg::EST_DROP]) *
	                  grsu_pkg::PROD_W'(recip);

	// bump the estimate when the magnitude reaches the next multiple of the divisor
	assign est_inc = {1'b0, est_q} + (grsu_pkg::WORD_W+1)'(1);
	assign bound   = grsu_pkg::BND_W'(est_inc) * grsu_pkg::BND_W'(div_val);
	assign take    = grsu_pkg::BND_W'(mag_q) >= bound;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= L_IDLE;
			done_q    <= 1'b0;
			gyro_q    <= 1'b0;
			num_q     <= '0;
			neg_q     <= 1'b0;
			pos_sat_q <= 1'b0;
			neg_sat_q <= 1'b0;
			mag_q     <= '0;
			est_q     <= '0;
			quo_q     <= '0;
		end else begin
			unique case (state_q)
				L_IDLE, L_DONE: begin
					if (start) begin
						state_q <= L_PREP;
						done_q  <= 1'b0;
						gyro_q  <= gyro_sel;
						num_q   <= num_d;
					end
				end
				L_PREP: begin
					state_q   <= L_EST;
					neg_q     <= num_q[grsu_pkg::NUM_W-1];
					pos_sat_q <= num_q >= sat_lim;
					neg_sat_q <= num_q <= -sat_lim;
					mag_q     <= num_abs[grsu_pkg::MAG_W-1:0];
				end
				L_EST: begin
					state_q <= L_FIX;
					est_q   <= est_prod[grsu_pkg::RECIP_SHIFT-grsu_pkg::EST_DROP +:
					                    grsu_pkg::WORD_W];
				end
				L_FIX: begin
					state_q <= L_DONE;
					done_q  <= 1'b1;
					quo_q   <= est_q[grsu_pkg::QUO_W-1:0] + grsu_pkg::QUO_W'(take);
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	assign quo_x = {1'b0, quo_q};

	always_comb begin
		lane_out.done = done_q;
		priority if (neg_sat_q) begin
			lane_out.word = {1'b1, {(grsu_pkg::WORD_W-1){1'b0}}};
		end else if (pos_sat_q) begin
			lane_out.word = {1'b0, {(grsu_pkg::WORD_W-1){1'b1}}};
		end else if (neg_q) begin
			// truncate toward zero: negate the magnitude quotient
			lane_out.word = grsu_pkg::WORD_W'(0) - quo_x;
		end else begin
			lane_out.word = quo_x;
		end
	end

endmodule

// ----- rtl/grsu_report.sv -----
// Report store and merge stage: buttons, axes, accel and gyro words.
// Combines the lane words with the stores and reports whether anything changed.
// Depends on grsu_pkg.
module grsu_report (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  commit,
	input  logic [grsu_pkg::OP_W-1:0]             operation,
	input  logic [grsu_pkg::INDEX_W-1:0]          index,
	input  logic                                  pressed,
	input  logic [grsu_pkg::WORD_W-1:0]           axis_value,
	input  logic [grsu_pkg::LANE_COUNT-1:0][grsu_pkg::WORD_W-1:0] words,
	output grsu_pkg::result_t                     result
);

	logic [grsu_pkg::WORD_W-1:0]                                  btn_q, btn_d;
	logic [grsu_pkg::AXIS_COUNT-1:0][grsu_pkg::WORD_W-1:0]        axis_q, axis_d;
	logic [grsu_pkg::LANE_COUNT-1:0][grsu_pkg::WORD_W-1:0]        accel_q, accel_d;
	logic [grsu_pkg::LANE_COUNT-1:0][grsu_pkg::WORD_W-1:0]        gyro_q, gyro_d;
	logic                                                         btn_ok;
	logic                                                         axis_ok;

	assign btn_ok  = index < grsu_pkg::INDEX_W'(grsu_pkg::BUTTON_COUNT);
	assign axis_ok = index < grsu_pkg::INDEX_W'(grsu_pkg::AXIS_COUNT);

	always_comb begin
		btn_d            = btn_q;
		axis_d           = axis_q;
		accel_d          = accel_q;
		gyro_d           = gyro_q;
		result.changed   = 1'b0;
		result.bad_index = 1'b0;
		unique case (operation)
			grsu_pkg::OP_CLEAR: begin
				btn_d          = '0;
				axis_d         = '0;
				accel_d        = '0;
				gyro_d         = '0;
				result.changed = 1'b1;
			end
			grsu_pkg::OP_SET_BUTTON: begin
				if (btn_ok) begin
					for (int i = 0; i < grsu_pkg::BUTTON_COUNT; i++) begin
						if (index == grsu_pkg::INDEX_W'(i)) begin
							btn_d[i] = pressed;
						end
					end
					result.changed = btn_d != btn_q;
				end else begin
					result.bad_index = 1'b1;
				end
			end
			grsu_pkg::OP_SET_AXIS: begin
				if (axis_ok) begin
					for (int i = 0; i < grsu_pkg::AXIS_COUNT; i++) begin
						if (index == grsu_pkg::INDEX_W'(i)) begin
							axis_d[i] = axis_value;
						end
					end
					result.changed = axis_d != axis_q;
				end else begin
					result.bad_index = 1'b1;
				end
			end
			grsu_pkg::OP_SET_ACCEL: begin
				accel_d        = words;
				result.changed = words != accel_q;
			end
			grsu_pkg::OP_SET_GYRO: begin
				gyro_d         = words;
				result.changed = words != gyro_q;
			end
			default: begin
			end
		endcase
		result.button_mask = btn_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btn_q   <= '0;
			axis_q  <= '0;
			accel_q <= '0;
			gyro_q  <= '0;
		end else if (commit) begin
			btn_q   <= btn_d;
			axis_q  <= axis_d;
			accel_q <= accel_d;
			gyro_q  <= gyro_d;
		end
	end

endmodule

// ----- rtl/gamepad_report_state_update_unit.sv -----
// Gamepad report state update unit: one operation item in, one report item out.
// Button, axis, clear and unused operations go from S_IDLE to S_COMMIT. For accel and gyro the
// unit waits in S_MOTION while 3 lanes step through prepare, reciprocal multiply and correct.
// S_COMMIT merges and registers the result once the output register is free, and only S_IDLE
// accepts the next item. A result waiting in the output register does not block the next
// accept. Reset (arst_n low) zeroes all stores and report_version and empties the channels.
module gamepad_report_state_update_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	grsu_cmd_if.sink    cmd,
	grsu_rpt_if.source  rpt
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MOTION,
		S_COMMIT
	} state_t;

	state_t                                                   state_q;
	logic [7:0]                                               report_version_q;
	logic [grsu_pkg::OP_W-1:0]                                op_q;
	logic [grsu_pkg::INDEX_W-1:0]                             index_q;
	logic                                                     pressed_q;
	logic [grsu_pkg::WORD_W-1:0]                              axis_q;
	logic                                                     out_valid_q;
	grsu_pkg::result_t                                        out_q;

	logic                                                     accept;
	logic                                                     motion_in;
	logic                                                     lane_start;
	logic                                                     out_free;
	logic                                                     commit;
	logic                                                     all_done;
	grsu_pkg::lane_out_t [grsu_pkg::LANE_COUNT-1:0]           lane_out;
	logic [grsu_pkg::LANE_COUNT-1:0][grsu_pkg::WORD_W-1:0]    words;
	logic signed [grsu_pkg::LANE_COUNT-1:0][grsu_pkg::MOTION_W-1:0] raw;
	grsu_pkg::result_t                                        result;

	assign cmd.ready  = state_q == S_IDLE;
	assign accept     = cmd.valid && cmd.ready;
	assign motion_in  = cmd.operation == grsu_pkg::OP_SET_ACCEL ||
	                    cmd.operation == grsu_pkg::OP_SET_GYRO;
	assign lane_start = accept && motion_in;
	assign out_free   = !out_valid_q || rpt.ready;
	assign commit     = state_q == S_COMMIT && out_free;

	assign raw[0] = cmd.motion_x;
	assign raw[1] = cmd.motion_y;
	assign raw[2] = cmd.motion_z;

	always_comb begin
		all_done = 1'b1;
		for (int i = 0; i < grsu_pkg::LANE_COUNT; i++) begin
			all_done = all_done & lane_out[i].done;
			words[i] = lane_out[i].word;
		end
	end

	for (genvar g = 0; g < grsu_pkg::LANE_COUNT; g++) begin : g_lane
		grsu_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (lane_start),
			.gyro_sel (cmd.operation == grsu_pkg::OP_SET_GYRO),
			.raw      (raw[g]),
			.lane_out (lane_out[g])
		);
	end

	grsu_report u_report (
		.clk        (clk),
		.arst_n     (arst_n),
		.commit     (commit),
		.operation  (op_q),
		.index      (index_q),
		.pressed    (pressed_q),
		.axis_value (axis_q),
		.words      (words),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_version_q <= '0;
		end else if (cfg_we) begin
			report_version_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			op_q        <= '0;
			index_q     <= '0;
			pressed_q   <= 1'b0;
			axis_q      <= '0;
			out_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q      <= cmd.operation;
						index_q   <= cmd.index;
						pressed_q <= cmd.pressed;
						axis_q    <= cmd.axis_value;
						state_q   <= motion_in ? S_MOTION : S_COMMIT;
					end
				end
				S_MOTION: begin
					// hold until every lane has its word
					if (all_done) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				out_valid_q <= 1'b1;
				out_q       <= result;
			end else if (rpt.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rpt.valid       = out_valid_q;
	assign rpt.changed     = out_q.changed;
	assign rpt.bad_index   = out_q.bad_index;
	assign rpt.button_mask = out_q.button_mask;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !cmd.ready)
		else $error("item accepted while another is in work");

	a_lanes_done: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && (op_q == grsu_pkg::OP_SET_ACCEL || op_q == grsu_pkg::OP_SET_GYRO))
		|-> all_done)
		else $error("motion result merged before all lanes finished");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> rpt.valid)
		else $error("merged result not presented");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && op_q == grsu_pkg::OP_CLEAR) |=> (rpt.changed && rpt.button_mask == '0))
		else $error("clear did not report an empty changed state");

	a_bad_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		rpt.valid |-> !(rpt.changed && rpt.bad_index))
		else $error("out-of-range index reported a change");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for gamepad_report_state_update_unit: directed, random, stall tests.
// Predicts each report item from its own copy of the report state and checks every result.
// Depends on grsu_pkg, grsu_cmd_if, grsu_rpt_if and the unit itself.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_PAUSE = 24;
	localparam int LONG_HOLD   = 300;
	localparam logic [grsu_pkg::OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [grsu_pkg::OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
	localparam logic signed [grsu_pkg::MOTION_W-1:0] MOTION_MIN = 32'sh8000_0000;
	localparam logic signed [grsu_pkg::MOTION_W-1:0] MOTION_MAX = 32'sh7FFF_FFFF;

	typedef struct {
		logic [grsu_pkg::OP_W-1:0]             op;
		logic [grsu_pkg::INDEX_W-1:0]          index;
		logic                                  pressed;
		logic signed [grsu_pkg::WORD_W-1:0]    axis_value;
		logic signed [grsu_pkg::MOTION_W-1:0]  mx;
		logic signed [grsu_pkg::MOTION_W-1:0]  my;
		logic signed [grsu_pkg::MOTION_W-1:0]  mz;
	} gp_op_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	grsu_cmd_if cmd_ch ();
	grsu_rpt_if rpt_ch ();

	gamepad_report_state_update_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.rpt       (rpt_ch)
	);

	// shadow of the report held by the unit
	grsu_pkg::word_t btn_bits;
	grsu_pkg::word_t axis_words [grsu_pkg::AXIS_COUNT];
	grsu_pkg::word_t accel_words [grsu_pkg::LANE_COUNT];
	grsu_pkg::word_t gyro_words [grsu_pkg::LANE_COUNT];
	logic [7:0]      version_shadow;

	grsu_pkg::result_t pending_reports [$];
	gp_op_t            last_accel;
	gp_op_t            last_gyro;

	int  mismatches    = 0;
	int  reports_seen  = 0;
	int  ops_sent      = 0;
	int  cfg_writes    = 0;
	int  long_holds    = 0;
	int  cycle_count   = 0;
	int  hold_request  = 0;
	bit  sender_idle   = 1'b1;
	bit  receiver_idle = 1'b1;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reports still due", cycle_count,
				pending_reports.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	function automatic grsu_pkg::word_t motion_to_word(
			input logic signed [grsu_pkg::MOTION_W-1:0] raw, input longint full_range);
		longint r;
		longint q;
		r = raw;
		q = (65535 * r - full_range) / (2 * full_range);
		if (q < -32768)
			q = -32768;
		if (q > 32767)
			q = 32767;
		return grsu_pkg::word_t'(q);
	endfunction

	function automatic grsu_pkg::result_t predict_report(input gp_op_t o);
		grsu_pkg::result_t res;
		grsu_pkg::word_t   prev;
		grsu_pkg::word_t   w [grsu_pkg::LANE_COUNT];
		longint            full_range;
		res.changed   = 1'b0;
		res.bad_index = 1'b0;
		full_range    = (o.op == grsu_pkg::OP_SET_ACCEL) ? grsu_pkg::ACCEL_RANGE
		                                                  : grsu_pkg::GYRO_RANGE;
		case (o.op)
			grsu_pkg::OP_CLEAR: begin
				btn_bits = '0;
				foreach (axis_words[i]) axis_words[i] = '0;
				foreach (accel_words[i]) accel_words[i] = '0;
				foreach (gyro_words[i]) gyro_words[i] = '0;
				res.changed = 1'b1;
			end
			grsu_pkg::OP_SET_BUTTON: begin
				if (o.index >= grsu_pkg::BUTTON_COUNT) begin
					res.bad_index = 1'b1;
				end else begin
					prev = btn_bits;
					btn_bits[o.index] = o.pressed;
					res.changed = (prev != btn_bits);
				end
			end
			grsu_pkg::OP_SET_AXIS: begin
				if (o.index >= grsu_pkg::AXIS_COUNT) begin
					res.bad_index = 1'b1;
				end else begin
					res.changed = (axis_words[o.index] != grsu_pkg::word_t'(o.axis_value));
					axis_words[o.index] = grsu_pkg::word_t'(o.axis_value);
				end
			end
			grsu_pkg::OP_SET_ACCEL, grsu_pkg::OP_SET_GYRO: begin
				w[0] = motion_to_word(o.mx, full_range);
				w[1] = motion_to_word(o.my, full_range);
				w[2] = motion_to_word(o.mz, full_range);
				for (int l = 0; l < grsu_pkg::LANE_COUNT; l++) begin
					if (o.op == grsu_pkg::OP_SET_ACCEL) begin
						if (accel_words[l] != w[l]) res.changed = 1'b1;
						accel_words[l] = w[l];
					end else begin
						if (gyro_words[l] != w[l]) res.changed = 1'b1;
						gyro_words[l] = w[l];
					end
				end
			end
			default: begin
				// unused codes leave the report alone
			end
		endcase
		res.button_mask = btn_bits;
		return res;
	endfunction

	function automatic gp_op_t make_op(input logic [grsu_pkg::OP_W-1:0] op, input int idx,
			input bit pressed, input int axis,
			input logic signed [grsu_pkg::MOTION_W-1:0] mx,
			input logic signed [grsu_pkg::MOTION_W-1:0] my,
			input logic signed [grsu_pkg::MOTION_W-1:0] mz);
		gp_op_t o;
		o.op         = op;
		o.index      = grsu_pkg::INDEX_W'(idx);
		o.pressed    = pressed;
		o.axis_value = grsu_pkg::WORD_W'(axis);
		o.mx         = mx;
		o.my         = my;
		o.mz         = mz;
		return o;
	endfunction

	// Aim at the saturation edges often, since that is where the scaling is most fragile.
	function automatic logic signed [grsu_pkg::MOTION_W-1:0] pick_motion(
			input longint full_range);
		longint v;
		case ($urandom_range(0, 5))
			0: v = $signed($urandom);
			1: v = longint'($urandom_range(0, 32'(2 * full_range))) - full_range;
			2: v = full_range + longint'($urandom_range(0, 400)) - 200;
			3: v = -full_range + longint'($urandom_range(0, 400)) - 200;
			4: v = $urandom_range(0, 1) ? MOTION_MAX : MOTION_MIN;
			default: v = longint'($urandom_range(0, 64)) - 32;
		endcase
		return grsu_pkg::MOTION_W'(v);
	endfunction

	function automatic logic [grsu_pkg::OP_W-1:0] pick_unused_op();
		return grsu_pkg::OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
	endfunction

	function automatic gp_op_t random_op();
		gp_op_t o;
		int     pick;
		longint full_range;
		o.index      = grsu_pkg::INDEX_W'($urandom);
		o.pressed    = 1'($urandom_range(0, 1));
		o.axis_value = grsu_pkg::WORD_W'($urandom);
		o.mx         = $signed($urandom);
		o.my         = $signed($urandom);
		o.mz         = $signed($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			o.op = grsu_pkg::OP_CLEAR;
		end else if (pick < 35) begin
			o.op = grsu_pkg::OP_SET_BUTTON;
			if ($urandom_range(0, 99) < 85)
				o.index = grsu_pkg::INDEX_W'($urandom_range(0, grsu_pkg::BUTTON_COUNT - 1));
		end else if (pick < 60) begin
			o.op = grsu_pkg::OP_SET_AXIS;
			if ($urandom_range(0, 99) < 85)
				o.index = grsu_pkg::INDEX_W'($urandom_range(0, grsu_pkg::AXIS_COUNT - 1));
		end else if (pick < 94) begin
			o.op = (pick < 77) ? grsu_pkg::OP_SET_ACCEL : grsu_pkg::OP_SET_GYRO;
			full_range = (o.op == grsu_pkg::OP_SET_ACCEL) ? grsu_pkg::ACCEL_RANGE
			                                               : grsu_pkg::GYRO_RANGE;
			// repeat the previous reading now and then so unchanged lanes show up
			if ($urandom_range(0, 99) < 15) begin
				o = (o.op == grsu_pkg::OP_SET_ACCEL) ? last_accel : last_gyro;
			end else begin
				o.mx = pick_motion(full_range);
				o.my = pick_motion(full_range);
				o.mz = pick_motion(full_range);
			end
		end else begin
			o.op = pick_unused_op();
		end
		return o;
	endfunction

	task automatic issue_op(input gp_op_t o);
		int gap;
		gap = sender_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			@(negedge clk);
			cmd_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_ch.valid      <= 1'b1;
		cmd_ch.operation  <= o.op;
		cmd_ch.index      <= o.index;
		cmd_ch.pressed    <= o.pressed;
		cmd_ch.axis_value <= o.axis_value;
		cmd_ch.motion_x   <= o.mx;
		cmd_ch.motion_y   <= o.my;
		cmd_ch.motion_z   <= o.mz;
		do @(posedge clk); while (!cmd_ch.ready);
		if (o.op == grsu_pkg::OP_SET_ACCEL)
			last_accel = o;
		else if (o.op == grsu_pkg::OP_SET_GYRO)
			last_gyro = o;
		pending_reports.push_back(predict_report(o));
		ops_sent++;
	endtask

	// Drop valid and wait until every report has come back.
	task automatic settle();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	task automatic write_version(input logic [7:0] v);
		settle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		version_shadow = v;
		cfg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed();
		issue_op(make_op(grsu_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0));
		issue_op(make_op(grsu_pkg::OP_SET_BUTTON, 0, 1, 0, 0, 0, 0));
		issue_op(make_op(grsu_pkg::OP_SET_BUTTON, 15, 1, 0, 0, 0, 0));
		issue_op(make_op(grsu_pkg::OP_SET_BUTTON, 15, 1, 0, 0, 0, 0));
		issue_op(make_op(grsu_pkg::OP_SET_BUTTON, 16, 1, -1, MOTION_MAX, 0, 0));
		issue_op(make_op(grsu_pkg::OP_SET_BUTTON, 31, 0, 0, 0, 0, 0));
		issue_op(make_op(grsu_pkg::OP_SET_BUTTON, 0, 0, 0, 0, 0, 0));
		issue_op(make_op(grsu_pkg::OP_SET_AXIS, 0, 0, -32768, 0, 0, 0));
		issue_op(make_op(grsu_pkg::OP_SET_AXIS, 5, 1, 32767, 0, 0, 0));
		issue_op(make_op(grsu_pkg::OP_SET_AXIS, 5, 0, 32767, 0, 0, 0));
		issue_op(make_op(grsu_pkg::OP_SET_AXIS, 6, 0, 123, 0, 0, 0));
		issue_op(make_op(grsu_pkg::OP_SET_AXIS, 31, 1, -1, 0, 0, 0));
		issue_op(make_op(grsu_pkg::OP_SET_ACCEL, 31, 1, -1, MOTION_MIN, MOTION_MAX, 0));
		issue_op(make_op(grsu_pkg::OP_SET_ACCEL, 0, 0, 0, MOTION_MIN, MOTION_MAX, 0));
		issue_op(make_op(grsu_pkg::OP_SET_ACCEL, 0, 0, 0, grsu_pkg::ACCEL_RANGE,
			-grsu_pkg::ACCEL_RANGE, grsu_pkg::ACCEL_RANGE - 1));
		issue_op(make_op(grsu_pkg::OP_SET_GYRO, 0, 0, 0, MOTION_MAX, MOTION_MIN,
			grsu_pkg::GYRO_RANGE));
		issue_op(make_op(grsu_pkg::OP_SET_GYRO, 0, 0, 0, -grsu_pkg::GYRO_RANGE,
			grsu_pkg::GYRO_RANGE + 1, 1));
		issue_op(make_op(grsu_pkg::OP_SET_GYRO, 0, 0, 0, 0, 0, 0));
		issue_op(make_op(grsu_pkg::OP_SET_ACCEL, 0, 0, 0, 0, 0, 0));
		issue_op(make_op(OP_UNUSED_FIRST, 3, 1, 5, 1, 2, 3));
		issue_op(make_op(OP_UNUSED_LAST, 31, 1, -1, MOTION_MIN, MOTION_MIN, MOTION_MIN));
		issue_op(make_op(grsu_pkg::OP_CLEAR, 31, 1, -1, MOTION_MAX, MOTION_MAX, MOTION_MAX));
		issue_op(make_op(grsu_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_random_mix(input int count);
		repeat (count) issue_op(random_op());
	endtask

	// Stall the report side for a long stretch while operations keep coming.
	task automatic test_back_pressure(input int count);
		sender_idle  = 1'b0;
		hold_request = LONG_HOLD;
		repeat (count) issue_op(random_op());
		sender_idle  = 1'b1;
	endtask

	task automatic test_no_idle(input int count);
		sender_idle   = 1'b0;
		receiver_idle = 1'b0;
		repeat (count) issue_op(random_op());
		sender_idle   = 1'b1;
		receiver_idle = 1'b1;
	endtask

	initial begin : report_sink
		int stall;
		rpt_ch.ready = 1'b0;
		forever begin
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
				long_holds++;
			end else begin
				stall = receiver_idle ? $urandom_range(0, 5) : 0;
			end
			if (stall > 0) begin
				@(negedge clk);
				rpt_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			rpt_ch.ready <= 1'b1;
			do @(posedge clk); while (!rpt_ch.valid);
		end
	end

	always @(posedge clk) begin
		grsu_pkg::result_t want;
		if (arst_n && rpt_ch.valid && rpt_ch.ready) begin
			reports_seen++;
			if (pending_reports.size() == 0) begin
				report_mismatch("report item with nothing expected");
			end else begin
				want = pending_reports.pop_front();
				if (rpt_ch.changed !== want.changed)
					report_mismatch($sformatf("changed %b, want %b", rpt_ch.changed,
						want.changed));
				if (rpt_ch.bad_index !== want.bad_index)
					report_mismatch($sformatf("bad_index %b, want %b", rpt_ch.bad_index,
						want.bad_index));
				if (rpt_ch.button_mask !== want.button_mask)
					report_mismatch($sformatf("button_mask %h, want %h", rpt_ch.button_mask,
						want.button_mask));
			end
		end
	end

	initial begin
		btn_bits = '0;
		foreach (axis_words[i]) axis_words[i] = '0;
		foreach (accel_words[i]) accel_words[i] = '0;
		foreach (gyro_words[i]) gyro_words[i] = '0;
		version_shadow = '0;
		last_accel = make_op(grsu_pkg::OP_SET_ACCEL, 0, 0, 0, 0, 0, 0);
		last_gyro  = make_op(grsu_pkg::OP_SET_GYRO, 0, 0, 0, 0, 0, 0);

		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.operation  = '0;
		cmd_ch.index      = '0;
		cmd_ch.pressed    = 1'b0;
		cmd_ch.axis_value = '0;
		cmd_ch.motion_x   = '0;
		cmd_ch.motion_y   = '0;
		cmd_ch.motion_z   = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		write_version(8'h00);
		test_directed();
		write_version(8'hFF);
		test_random_mix(700);
		write_version(8'($urandom));
		test_back_pressure(60);
		write_version(8'h01);
		test_no_idle(200);
		write_version(8'h80);
		test_random_mix(470);

		settle();
		if (pending_reports.size() != 0)
			report_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));
		$display("Ran %0d operations and checked %0d report items across %0d version writes,",
			ops_sent, reports_seen, cfg_writes);
		$display("with random idling, %0d long report stall(s) and back-to-back stretches.",
			long_holds);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

// ----- gamepad_report_state_update_unit.f -----
rtl/grsu_pkg.sv
rtl/grsu_cmd_if.sv
rtl/grsu_rpt_if.sv
rtl/grsu_lane.sv
rtl/grsu_report.sv
rtl/gamepad_report_state_update_unit.sv
sim/tb_top.sv
